// ----- design/kes_pkg.sv -----
package kes_pkg;

    localparam int KEY_W         = 14;
    localparam int TAG_W         = 5;
    localparam int MAX_ITEMS_DEF = 32;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_LOAD  = 4'b0100,
        S_CMP   = 4'b1000
    } state_t;

endpackage

// ----- design/kes_ram.sv -----
module kes_ram
    import kes_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = MAX_ITEMS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/kes_cmp.sv -----
module kes_cmp
    import kes_pkg::*;
(
    input  logic [KEY_W-1:0] held_key,
    input  logic [KEY_W-1:0] later_key,
    input  logic             descending,
    output logic             swap
);

    // strict compare: equal keys never swap
    always_comb
    begin
        if (descending)
        begin
            swap = (held_key < later_key);
        end
        else
        begin
            swap = (held_key > later_key);
        end
    end

endmodule

// ----- design/keyed_exchange_sort_unit.sv -----
// Loading: pairs are taken while busy stays low. After the last pair, pass i of the
//   sort fetches position i, then compares it with each later position; the pair for
//   position i leaves at the end of pass i.
// One list at a time; busy is high from the last pair to the final result.
// Results cannot be stalled: each is valid for exactly one cycle under strobe.
// Reset (async, rst_n low): empty list, no overflow, descending order; RAM not cleared.
module keyed_exchange_sort_unit
    import kes_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    // command side
    input  logic             start,
    output logic             busy,
    input  logic [KEY_W-1:0] key,
    input  logic [TAG_W-1:0] tag,
    input  logic             last_in,
    // configuration
    input  logic             cfg_write,
    input  logic             cfg_data,
    // results
    output logic             strobe,
    output logic [KEY_W-1:0] sorted_key,
    output logic [TAG_W-1:0] sorted_tag,
    output logic             last_out,
    output logic             overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

    // Sort scheme: the entry at position i is held in cur_reg while positions
    // j > i stream out of the RAM. On a swap the held entry is written to j and
    // the entry read from j becomes the held one. Position i is final at the end
    // of its pass, so it is emitted right there and never written back.

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic            desc_cfg_reg, desc_cfg_next;
    logic            desc_reg, desc_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    entry_t          cur_reg, cur_next;

    logic            strobe_reg, strobe_next;
    entry_t          out_reg, out_next;
    logic            olast_reg, olast_next;
    logic            oovf_reg, oovf_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    entry_t          ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t          rd_entry;
    logic            swap;
    logic            accept;
    logic            has_room;

    assign rd_entry = entry_t'(ram_rdata);
    assign accept   = start && !busy;
    assign has_room = (count_reg < MAX_C);

    kes_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ITEMS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared compare unit
    kes_cmp u_cmp (
        .held_key   (cur_reg.key),
        .later_key  (rd_entry.key),
        .descending (desc_reg),
        .swap       (swap)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        desc_cfg_next = cfg_write ? cfg_data : desc_cfg_reg;
        desc_next     = desc_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        cur_next      = cur_reg;
        strobe_next   = 1'b0;
        out_next      = out_reg;
        olast_next    = olast_reg;
        oovf_next     = oovf_reg;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[AW-1:0];
        ram_wdata     = '{key: key, tag: tag};
        ram_raddr     = i_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // full store: pair is dropped and flagged
                    if (has_room)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_in)
                    begin
                        n_next     = has_room ? count_reg + 1'b1 : count_reg;
                        desc_next  = desc_cfg_reg;
                        i_next     = '0;
                        state_next = S_FETCH;
                    end
                end
            end

            S_FETCH:
            begin
                ram_raddr  = i_reg[AW-1:0];
                j_next     = i_reg + 1'b1;
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                cur_next = rd_entry;
                if (j_reg < n_reg)
                begin
                    ram_raddr  = j_reg[AW-1:0];
                    state_next = S_CMP;
                end
                else
                begin
                    // final position: nothing left to compare against
                    strobe_next = 1'b1;
                    out_next    = rd_entry;
                    olast_next  = 1'b1;
                    oovf_next   = ovf_reg;
                    count_next  = '0;
                    ovf_next    = 1'b0;
                    state_next  = S_IDLE;
                end
            end

            S_CMP:
            begin
                if (swap)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = j_reg[AW-1:0];
                    ram_wdata = cur_reg;
                    cur_next  = rd_entry;
                end
                if ((j_reg + 1'b1) < n_reg)
                begin
                    ram_raddr = AW'(j_reg + 1'b1);
                    j_next    = j_reg + 1'b1;
                end
                else
                begin
                    // pass done, position i settled
                    strobe_next = 1'b1;
                    out_next    = swap ? rd_entry : cur_reg;
                    olast_next  = 1'b0;
                    oovf_next   = ovf_reg;
                    i_next      = i_reg + 1'b1;
                    state_next  = S_FETCH;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            desc_cfg_reg <= 1'b1;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            desc_cfg_reg <= desc_cfg_next;
            strobe_reg   <= strobe_next;
        end
    end

    // payload and loop registers, no reset needed
    always_ff @(posedge clk)
    begin
        desc_reg  <= desc_next;
        n_reg     <= n_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        cur_reg   <= cur_next;
        out_reg   <= out_next;
        olast_reg <= olast_next;
        oovf_reg  <= oovf_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign strobe     = strobe_reg;
    assign sorted_key = out_reg.key;
    assign sorted_tag = out_reg.tag;
    assign last_out   = olast_reg;
    assign overflow   = oovf_reg;

    // the final result of a list coincides with the block going idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_out |-> !busy)
        else $error("final result while still sorting");

    // the sort only ends by delivering the final result
    a_fall_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && last_out)
        else $error("sort ended without a final result");

    // compare index stays inside the held list
    a_j_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> j_reg < n_reg && i_reg < j_reg)
        else $error("compare index out of range");

    // a pair without the last mark keeps the block loading
    a_load_stay: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !last_in |=> !busy && !strobe)
        else $error("sort started without last pair");

endmodule

// ----- tb/sv/kes_order_checker.sv -----
`timescale 1ns / 100ps
module kes_order_checker
    import kes_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [KEY_W-1:0] key,
    input  logic [TAG_W-1:0] tag,
    input  logic             last_in,
    input  logic             cfg_write,
    input  logic             cfg_data,
    input  logic             strobe,
    input  logic [KEY_W-1:0] sorted_key,
    input  logic [TAG_W-1:0] sorted_tag,
    input  logic             last_out,
    input  logic             overflow,
    output int               fail_count,
    output int               pending_results
);

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
        logic             ovf;
    } sorted_pair_t;

    sorted_pair_t sorted_pairs_q[$];
    entry_t       held_pairs[MAX_ITEMS];
    int           held_count;
    bit           held_overflow;
    bit           descending;

    function automatic bit out_of_order(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
        return descending ? (a < b) : (a > b);
    endfunction

    // exchange sort of the held list, then one expected result per held pair
    function automatic void queue_sorted_list();
        entry_t       tmp;
        sorted_pair_t res;
        for (int i = 0; i < held_count; i++)
        begin
            for (int j = i + 1; j < held_count; j++)
            begin
                if (out_of_order(held_pairs[i].key, held_pairs[j].key))
                begin
                    tmp           = held_pairs[i];
                    held_pairs[i] = held_pairs[j];
                    held_pairs[j] = tmp;
                end
            end
        end
        for (int k = 0; k < held_count; k++)
        begin
            res.key  = held_pairs[k].key;
            res.tag  = held_pairs[k].tag;
            res.last = (k == held_count - 1);
            res.ovf  = held_overflow;
            sorted_pairs_q.push_back(res);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sorted_pair_t exp_pair;
        if (!rst_n)
        begin
            sorted_pairs_q.delete();
            held_count    = 0;
            held_overflow = 1'b0;
            descending    = 1'b1;
            fail_count    = 0;
        end
        else
        begin
            if (strobe)
            begin
                if (sorted_pairs_q.size() == 0)
                begin
                    $error("unexpected result: sorted_key %0d sorted_tag %0d",
                           sorted_key, sorted_tag);
                    fail_count++;
                end
                else
                begin
                    exp_pair = sorted_pairs_q.pop_front();
                    if (sorted_key !== exp_pair.key)
                    begin
                        $error("sorted_key mismatch: expected %0d, actual %0d",
                               exp_pair.key, sorted_key);
                        fail_count++;
                    end
                    if (sorted_tag !== exp_pair.tag)
                    begin
                        $error("sorted_tag mismatch: expected %0d, actual %0d",
                               exp_pair.tag, sorted_tag);
                        fail_count++;
                    end
                    if (last_out !== exp_pair.last)
                    begin
                        $error("last_out mismatch: expected %0d, actual %0d",
                               exp_pair.last, last_out);
                        fail_count++;
                    end
                    if (overflow !== exp_pair.ovf)
                    begin
                        $error("overflow mismatch: expected %0d, actual %0d",
                               exp_pair.ovf, overflow);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                // full store drops the pair, last one included
                if (held_count < MAX_ITEMS)
                begin
                    held_pairs[held_count].key = key;
                    held_pairs[held_count].tag = tag;
                    held_count++;
                end
                else
                    held_overflow = 1'b1;
                if (last_in)
                begin
                    queue_sorted_list();
                    held_count    = 0;
                    held_overflow = 1'b0;
                end
            end
            if (cfg_write)
                descending = cfg_data;
        end
        pending_results <= sorted_pairs_q.size();
    end

endmodule

// ----- tb/sv/tb_keyed_exchange_sort_unit.sv -----
`timescale 1ns / 100ps
module tb_keyed_exchange_sort_unit;
    import kes_pkg::*;

    localparam int LIST_DEPTH   = MAX_ITEMS_DEF;
    localparam int RANDOM_ITEMS = 310;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last_in;
    logic             cfg_write;
    logic             cfg_data;
    logic             strobe;
    logic [KEY_W-1:0] sorted_key;
    logic [TAG_W-1:0] sorted_tag;
    logic             last_out;
    logic             overflow;

    int fail_count;
    int pending_results;
    int idle_pct;       // chance in percent that the sender skips a cycle
    int items_sent;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    keyed_exchange_sort_unit #(
        .MAX_ITEMS (LIST_DEPTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .key        (key),
        .tag        (tag),
        .last_in    (last_in),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .strobe     (strobe),
        .sorted_key (sorted_key),
        .sorted_tag (sorted_tag),
        .last_out   (last_out),
        .overflow   (overflow)
    );

    // watches every transfer, predicts the sorted lists and compares
    kes_order_checker #(
        .MAX_ITEMS (LIST_DEPTH)
    ) u_order_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .key             (key),
        .tag             (tag),
        .last_in         (last_in),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .strobe          (strobe),
        .sorted_key      (sorted_key),
        .sorted_tag      (sorted_tag),
        .last_out        (last_out),
        .overflow        (overflow),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // One pair transfer. Gap cycles drop start and put junk on the data lines,
    // which the block must ignore. start stays high after the transfer so that
    // back-to-back pairs never see a low/high pair of assignments in one step.
    task automatic send_pair(input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t,
                             input logic l);
        while ($urandom_range(99) < idle_pct)
        begin
            start   <= 1'b0;
            key     <= KEY_W'($urandom);
            tag     <= TAG_W'($urandom);
            last_in <= 1'($urandom);
            @(posedge clk);
        end
        start   <= 1'b1;
        key     <= k;
        tag     <= t;
        last_in <= l;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    // drop start and wait until the block has drained its list
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (busy || pending_results != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // direction register, written only with the block idle
    task automatic write_direction(input logic descending);
        settle();
        cfg_write <= 1'b1;
        cfg_data  <= descending;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // mostly in-range keys, some from a coarse grid to force ties, some
    // over the full 14 bits (above 10000 they are just bigger numbers)
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(9))
            0:       k = KEY_W'($urandom);
            1, 2:    k = KEY_W'($urandom_range(8) * 1250);
            default: k = KEY_W'($urandom_range(10000));
        endcase
        return k;
    endfunction

    // short lists dominate; a few fill the store or run past it
    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(6, 1);
        else if (r < 85)
            return $urandom_range(16, 7);
        else if (r < 95)
            return $urandom_range(LIST_DEPTH, 17);
        return $urandom_range(LIST_DEPTH + 8, LIST_DEPTH + 1);
    endfunction

    task automatic send_list(input int len);
        for (int n = 0; n < len; n++)
            send_pair(pick_key(), TAG_W'($urandom), n == len - 1);
    endtask

    initial
    begin
        int phase_pct[3] = '{0, 88, 25};
        int list_no;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        key       <= '0;
        tag       <= '0;
        last_in   <= 1'b0;
        cfg_write <= 1'b0;
        cfg_data  <= 1'b0;
        idle_pct   = 0;
        items_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset direction is descending. Extremes of key and tag,
        // a key above 10000, three equal keys with distinct tags.
        send_pair(14'd5000,  5'd1,  1'b0);
        send_pair(14'd0,     5'd0,  1'b0);
        send_pair(14'd10000, 5'd31, 1'b0);
        send_pair(14'd5000,  5'd2,  1'b0);
        send_pair(14'd16383, 5'd7,  1'b0);
        send_pair(14'd5000,  5'd3,  1'b1);
        // single-pair list
        send_pair(14'd1234,  5'd9,  1'b1);

        // same shape, ascending
        write_direction(1'b0);
        send_pair(14'd10000, 5'd4,  1'b0);
        send_pair(14'd0,     5'd5,  1'b0);
        send_pair(14'd5000,  5'd6,  1'b0);
        send_pair(14'd0,     5'd17, 1'b0);
        send_pair(14'd16383, 5'd31, 1'b0);
        send_pair(14'd9999,  5'd10, 1'b1);
        send_pair(14'd0,     5'd0,  1'b1);

        // Random lists in idling phases. The first two lists fill the store
        // exactly and then overrun it by one, so the last pair is dropped.
        items_sent = 0;
        list_no    = 0;
        foreach (phase_pct[p])
        begin
            write_direction(p % 2 == 1);
            idle_pct = phase_pct[p];
            while (items_sent < (p + 1) * RANDOM_ITEMS / 3)
            begin
                if (list_no > 1 && $urandom_range(3) == 0)
                    write_direction(1'($urandom));
                if (list_no == 0)
                    send_list(LIST_DEPTH);
                else if (list_no == 1)
                    send_list(LIST_DEPTH + 1);
                else
                    send_list(pick_len());
                list_no++;
            end
        end

        // drain, then a few quiet cycles for any stray strobe
        settle();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- keyed_exchange_sort_unit.f -----
design/kes_pkg.sv
design/kes_ram.sv
design/kes_cmp.sv
design/keyed_exchange_sort_unit.sv
tb/sv/kes_order_checker.sv
tb/sv/tb_keyed_exchange_sort_unit.sv
